// ===== rtl/core/tji_pkg.sv =====
// Package with payload types and fixed constants of the tetrahedron Jacobian inverse unit.
`timescale 1ns / 1ps
package tji_pkg;

  localparam int CoordW = 16;
  localparam int DiffW  = 17;
  localparam int Cof2W  = 35;
  localparam int DetW   = 52;
  localparam int VolW   = 49;
  localparam int ThrW   = 40;
  localparam int InvW   = 32;
  // Holds the scaled adjugate numerator up to twelve coordinate fraction bits.
  localparam int QuotW  = 63;

  typedef struct packed {
    logic signed [CoordW-1:0] x_a;
    logic signed [CoordW-1:0] y_a;
    logic signed [CoordW-1:0] z_a;
    logic signed [CoordW-1:0] x_b;
    logic signed [CoordW-1:0] y_b;
    logic signed [CoordW-1:0] z_b;
    logic signed [CoordW-1:0] x_c;
    logic signed [CoordW-1:0] y_c;
    logic signed [CoordW-1:0] z_c;
    logic signed [CoordW-1:0] x_d;
    logic signed [CoordW-1:0] y_d;
    logic signed [CoordW-1:0] z_d;
  } tji_in_t;

  typedef struct packed {
    logic signed [DetW-1:0] det_value;
    logic [VolW-1:0]        volume;
    logic signed [InvW-1:0] inv_r0_c0;
    logic signed [InvW-1:0] inv_r0_c1;
    logic signed [InvW-1:0] inv_r0_c2;
    logic signed [InvW-1:0] inv_r1_c0;
    logic signed [InvW-1:0] inv_r1_c1;
    logic signed [InvW-1:0] inv_r1_c2;
    logic signed [InvW-1:0] inv_r2_c0;
    logic signed [InvW-1:0] inv_r2_c1;
    logic signed [InvW-1:0] inv_r2_c2;
    logic                   status;
  } tji_out_t;

endpackage

// ===== rtl/core/tji_div_stage.sv =====
// One radix-2 restoring step of the pipelined divider, applied to nine lanes at once.
`timescale 1ns / 1ps
module tji_div_stage
  import tji_pkg::*;
#(
  parameter int RemW = 53
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [9*RemW-1:0]     rem_i,
  input  logic [9*QuotW-1:0]    num_i,
  input  logic [9*QuotW-1:0]    quo_i,
  input  logic [DetW-1:0]       den_i,
  output logic [9*RemW-1:0]     rem_o,
  output logic [9*QuotW-1:0]    num_o,
  output logic [9*QuotW-1:0]    quo_o
);

  logic [9*RemW-1:0]  rem_nxt;
  logic [9*QuotW-1:0] num_nxt;
  logic [9*QuotW-1:0] quo_nxt;
  logic [9*RemW-1:0]  rem_r;
  logic [9*QuotW-1:0] num_r;
  logic [9*QuotW-1:0] quo_r;

  // Shift in the next numerator bit, subtract the divisor when it fits.
  always_comb begin
    logic [RemW:0] trial;
    logic [RemW:0] diff;
    for (int l = 0; l < 9; l++) begin
      trial = {rem_i[l*RemW +: RemW], num_i[l*QuotW + QuotW-1]};
      diff  = trial - {{(RemW+1-DetW){1'b0}}, den_i};
      if (!diff[RemW]) begin
        rem_nxt[l*RemW +: RemW] = diff[RemW-1:0];
        quo_nxt[l*QuotW +: QuotW] = {quo_i[l*QuotW +: QuotW-1], 1'b1};
      end else begin
        rem_nxt[l*RemW +: RemW] = trial[RemW-1:0];
        quo_nxt[l*QuotW +: QuotW] = {quo_i[l*QuotW +: QuotW-1], 1'b0};
      end
      num_nxt[l*QuotW +: QuotW] = {num_i[l*QuotW +: QuotW-1], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rem_o = rem_r;
  assign num_o = num_r;
  assign quo_o = quo_r;

endmodule

// ===== rtl/core/tji_front.sv =====
// Front pipeline: edge vectors, 2x2 cofactors and the determinant.
`timescale 1ns / 1ps
module tji_front
  import tji_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  tji_in_t                 in_word,
  output logic                    out_vld,
  output logic signed [DetW-1:0]  det_o,
  output logic signed [Cof2W-1:0] adj_o [9]
);

  logic                    v1_r, v2_r, v3_r;
  logic signed [DiffW-1:0] jm_r [3][3];
  logic signed [DiffW-1:0] jm2_r [3];
  logic signed [Cof2W-1:0] adj_r [9];
  logic signed [Cof2W-1:0] adj3_r [9];
  logic signed [DetW-1:0]  t_r [3];
  logic signed [DetW-1:0]  det_r;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage 1: Jacobian columns are edges from vertex a.
  always_ff @(posedge clk) begin
    jm_r[0][0] <= DiffW'(in_word.x_b) - DiffW'(in_word.x_a);
    jm_r[0][1] <= DiffW'(in_word.x_c) - DiffW'(in_word.x_a);
    jm_r[0][2] <= DiffW'(in_word.x_d) - DiffW'(in_word.x_a);
    jm_r[1][0] <= DiffW'(in_word.y_b) - DiffW'(in_word.y_a);
    jm_r[1][1] <= DiffW'(in_word.y_c) - DiffW'(in_word.y_a);
    jm_r[1][2] <= DiffW'(in_word.y_d) - DiffW'(in_word.y_a);
    jm_r[2][0] <= DiffW'(in_word.z_b) - DiffW'(in_word.z_a);
    jm_r[2][1] <= DiffW'(in_word.z_c) - DiffW'(in_word.z_a);
    jm_r[2][2] <= DiffW'(in_word.z_d) - DiffW'(in_word.z_a);
  end

  // Stage 2: adjugate entries; entry (i,k) sits at index i*3+k.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        adj_r[i*3+k] <= Cof2W'(jm_r[(k+1)%3][(i+1)%3] * jm_r[(k+2)%3][(i+2)%3])
                      - Cof2W'(jm_r[(k+1)%3][(i+2)%3] * jm_r[(k+2)%3][(i+1)%3]);
      end
      jm2_r[i] <= jm_r[0][i];
    end
  end

  // Stage 3: products of the top row with the first adjugate column.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      t_r[i] <= DetW'(jm2_r[i]) * DetW'(adj_r[i*3]);
    end
    adj3_r <= adj_r;
  end

  // Stage 4: determinant sum.
  always_ff @(posedge clk) begin
    det_r <= t_r[0] + t_r[1] + t_r[2];
    adj_o <= adj3_r;
  end

  logic v4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  assign out_vld = v4_r;
  assign det_o   = det_r;

endmodule

// ===== rtl/core/tji_divider.sv =====
// Pipelined nine-lane divider with saturation, plus volume by six and the status flag.
`timescale 1ns / 1ps
module tji_divider
  import tji_pkg::*;
#(
  parameter int FracBits = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  logic signed [DetW-1:0]  det_i,
  input  logic signed [Cof2W-1:0] adj_i [9],
  input  logic [ThrW-1:0]         thr_i,
  output logic                    out_vld,
  output tji_out_t                out_word
);

  localparam int Shift = FracBits + 16;
  localparam int NumW  = Cof2W + Shift;
  localparam int Steps = NumW;
  localparam int RemW  = DetW + 1;
  localparam logic [19:0] Recip3 = 20'd349526;

  logic [Steps:0] vld_r;
  logic [DetW-1:0]    den_r [Steps+1];
  logic [DetW-1:0]    det_p_r [Steps+1];
  logic [8:0]         neg_p_r [Steps+1];
  logic               ok_p_r [Steps+1];
  logic [9*QuotW-1:0] num_in;
  logic [8:0]         neg_in;
  logic               ok_in;

  // Quotient by three of a digit below three times 2^17, with its remainder on top.
  function automatic logic [18:0] div3(logic [18:0] v);
    logic [38:0] prod;
    logic [16:0] q;
    logic [18:0] r;
    prod = {20'd0, v} * {19'd0, Recip3};
    q = prod[36:20];
    r = v - {1'b0, q, 1'b0} - {2'd0, q};
    return {r[1:0], q};
  endfunction

  // Entry: magnitudes, sign bits and validity against the threshold.
  always_comb begin
    logic [Cof2W-1:0] mag;
    ok_in = !det_i[DetW-1] && (det_i > $signed({{(DetW-ThrW){1'b0}}, thr_i}));
    for (int l = 0; l < 9; l++) begin
      mag = adj_i[l][Cof2W-1] ? Cof2W'(-adj_i[l]) : adj_i[l];
      neg_in[l] = adj_i[l][Cof2W-1];
      num_in[l*QuotW +: QuotW] = QuotW'({mag, {Shift{1'b0}}}) << (QuotW - NumW);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[Steps-1:0], in_vld};
    end
  end

  // Side data travels alongside each divider stage.
  always_ff @(posedge clk) begin
    den_r[0]   <= ok_in ? det_i : DetW'(1);
    det_p_r[0] <= det_i;
    neg_p_r[0] <= neg_in;
    ok_p_r[0]  <= ok_in;
    for (int s = 1; s <= Steps; s++) begin
      den_r[s]   <= den_r[s-1];
      det_p_r[s] <= det_p_r[s-1];
      neg_p_r[s] <= neg_p_r[s-1];
      ok_p_r[s]  <= ok_p_r[s-1];
    end
  end

  logic [9*RemW-1:0]  rem0_r;
  logic [9*QuotW-1:0] num0_r;
  logic [9*QuotW-1:0] quo0_r;
  always_ff @(posedge clk) begin
    rem0_r <= '0;
    num0_r <= num_in;
    quo0_r <= '0;
  end

  logic [9*RemW-1:0]  rem_s [Steps+1];
  logic [9*QuotW-1:0] num_s [Steps+1];
  logic [9*QuotW-1:0] quo_s [Steps+1];
  assign rem_s[0] = rem0_r;
  assign num_s[0] = num0_r;
  assign quo_s[0] = quo0_r;

  // One quotient bit per stage.
  for (genvar s = 0; s < Steps; s++) begin : g_stage
    tji_div_stage #(.RemW(RemW)) u_stage (
      .clk  (clk),
      .en   (1'b1),
      .rem_i(rem_s[s]),
      .num_i(num_s[s]),
      .quo_i(quo_s[s]),
      .den_i(den_r[s]),
      .rem_o(rem_s[s+1]),
      .num_o(num_s[s+1]),
      .quo_o(quo_s[s+1])
    );
  end

  // Volume: half the determinant divided by three, one 17-bit digit per
  // cycle over the last three divider stages, so it lines up with the quotients.
  logic [18:0]     d3a, d3b, d3c;
  logic [16:0]     v6q_hi_r;
  logic [16:0]     v6q_hi2_r;
  logic [16:0]     v6q_mid_r;
  logic [1:0]      v6rem_a_r;
  logic [1:0]      v6rem_b_r;
  logic [VolW-1:0] v6_vol_r;

  assign d3a = div3({3'd0, det_p_r[Steps-3][DetW-2 -: 16]});
  assign d3b = div3({v6rem_a_r, det_p_r[Steps-2][DetW-18 -: 17]});
  assign d3c = div3({v6rem_b_r, det_p_r[Steps-1][DetW-35 -: 17]});

  always_ff @(posedge clk) begin
    v6q_hi_r  <= d3a[16:0];
    v6rem_a_r <= d3a[18:17];
    v6q_hi2_r <= v6q_hi_r;
    v6q_mid_r <= d3b[16:0];
    v6rem_b_r <= d3b[18:17];
    v6_vol_r  <= VolW'({v6q_hi2_r, v6q_mid_r, d3c[16:0]});
  end

  // Final stage: saturation, volume and status.
  tji_out_t res_nxt;
  tji_out_t res_r;
  logic     vout_r;
  always_comb begin
    logic [QuotW-1:0]       q;
    logic signed [InvW-1:0] e;
    logic [InvW-1:0]        ent [9];
    for (int l = 0; l < 9; l++) begin
      q = quo_s[Steps][l*QuotW +: QuotW];
      if (neg_p_r[Steps][l]) begin
        e = (q > QuotW'(32'h8000_0000)) ? 32'sh8000_0000 : InvW'(-q);
      end else begin
        e = (q > QuotW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : InvW'(q);
      end
      ent[l] = ok_p_r[Steps] ? e : '0;
    end
    res_nxt.det_value = det_p_r[Steps];
    res_nxt.volume    = ok_p_r[Steps] ? v6_vol_r : '0;
    res_nxt.inv_r0_c0 = ent[0];
    res_nxt.inv_r0_c1 = ent[1];
    res_nxt.inv_r0_c2 = ent[2];
    res_nxt.inv_r1_c0 = ent[3];
    res_nxt.inv_r1_c1 = ent[4];
    res_nxt.inv_r1_c2 = ent[5];
    res_nxt.inv_r2_c0 = ent[6];
    res_nxt.inv_r2_c1 = ent[7];
    res_nxt.inv_r2_c2 = ent[8];
    res_nxt.status    = !ok_p_r[Steps];
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else begin
      vout_r <= vld_r[Steps];
    end
  end

  assign out_vld  = vout_r;
  assign out_word = res_r;

endmodule

// ===== rtl/core/tetra_jacobian_inverse_unit.sv =====
// Top level of the tetrahedron Jacobian determinant and inverse unit.
//
// Channel  Ports                          Direction  Handshake
// input    start, busy, in_word           in         word taken when start && !busy
// result   out_strobe, out_word           out        one-cycle strobe, no back-pressure
// config   cfg_valid, cfg_ready, cfg_data in         written when cfg_valid && cfg_ready
//
// A word enters every cycle; busy stays low. The path runs through four Jacobian
// and determinant stages, one entry register, 59 divider bit stages at the
// default fraction width and one output register.
// Synchronous active-low reset clears all valid bits and the threshold.
// The result side cannot stall, so nothing in the pipeline ever holds.
`timescale 1ns / 1ps
module tetra_jacobian_inverse_unit
  import tji_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  tji_in_t         in_word,
  output logic            out_strobe,
  output tji_out_t        out_word,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [ThrW-1:0] cfg_data
);

  logic [ThrW-1:0]         thr_r;
  logic                    f_vld;
  logic signed [DetW-1:0]  f_det;
  logic signed [Cof2W-1:0] f_adj [9];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  tji_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (start),
    .in_word(in_word),
    .out_vld(f_vld),
    .det_o  (f_det),
    .adj_o  (f_adj)
  );

  tji_divider #(.FracBits(COORD_FRAC_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (f_vld),
    .det_i   (f_det),
    .adj_i   (f_adj),
    .thr_i   (thr_r),
    .out_vld (out_strobe),
    .out_word(out_word)
  );

endmodule
